// ----- design/sentence_boundary_splitter_defines.svh -----
// ---------------------------------------------------------------------------
// Sentence boundary splitter assertion macros
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef SENTENCE_BOUNDARY_SPLITTER_DEFINES_SVH
`define SENTENCE_BOUNDARY_SPLITTER_DEFINES_SVH

`ifndef SYNTHESIS

// The antecedent implies the consequent in the same cycle.
`define SBS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sentence_boundary_splitter: assertion failed");

// The antecedent implies the consequent in the next cycle.
`define SBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sentence_boundary_splitter: assertion failed");

`else

`define SBS_ASSERT_SAME(label, ante, cons)
`define SBS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- design/sbs_pkg.sv -----
// ---------------------------------------------------------------------------
// Sentence boundary splitter package
// Byte classes, abbreviation matcher and default sizes.
// ---------------------------------------------------------------------------
`default_nettype none

package sbs_pkg;

  localparam longint unsigned MaxTextBytesDefault = 64'd65536;
  localparam int unsigned     WordWindowDefault   = 4;
  localparam int unsigned     OffsetWidth         = 16;

  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChBang   = 8'h21;
  localparam logic [7:0] ChQuest  = 8'h3F;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChRparen = 8'h29;
  localparam logic [7:0] ChRbrack = 8'h5D;
  localparam logic [7:0] ChUtfLead = 8'hE2;
  localparam logic [7:0] CaseBit  = 8'h20;

  function automatic logic is_ws_byte(input logic [7:0] c);
    return (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return c >= 8'h41 && c <= 8'h5A;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return is_upper(c) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_closing_byte(input logic [7:0] c);
    return (c == ChDquote) || (c == ChSquote) || (c == ChRparen) ||
           (c == ChRbrack) || (c == ChUtfLead);
  endfunction

  // tail holds the four newest window bytes, the newest in the low byte.
  function automatic logic abbrev_match(input logic [31:0] tail,
                                        input logic len2,
                                        input logic len3,
                                        input logic len4);
    logic m2;
    logic m3;
    logic m4;
    m2 = (tail[15:0] == "mr") || (tail[15:0] == "ms") || (tail[15:0] == "dr") ||
         (tail[15:0] == "st") || (tail[15:0] == "jr") || (tail[15:0] == "sr") ||
         (tail[15:0] == "vs") || (tail[15:0] == "no");
    m3 = (tail[23:0] == "mrs") || (tail[23:0] == "etc") || (tail[23:0] == "e.g") ||
         (tail[23:0] == "i.e") || (tail[23:0] == "fig");
    m4 = (tail == "prof");
    return (len2 && m2) || (len3 && m3) || (len4 && m4);
  endfunction

endpackage

`default_nettype wire

// ----- design/sentence_boundary_splitter.sv -----
// ---------------------------------------------------------------------------
// Sentence boundary splitter
// Reports each trimmed sentence of a byte stream as first/last offsets.
// ---------------------------------------------------------------------------
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+------------------------------
//   in      | input     | in_valid_i/in_ready_o | text_byte_i, end_of_text_i
//   out     | output    | out_valid_o/out_ready_i | sentence_found_o,
//           |           |                       | start_offset_o, end_offset_o,
//           |           |                       | text_done_o, length_overflow_o
//
// One byte is taken per cycle while in_ready_o is high; its result, if any,
// appears in the single result register on the next cycle.
// A byte is still taken while a result waits, provided out_ready_i is high.
// Reset clears all control state; no clearing pass is needed.
`default_nettype none

`include "sentence_boundary_splitter_defines.svh"

module sentence_boundary_splitter #(
  parameter longint unsigned MaxTextBytes = sbs_pkg::MaxTextBytesDefault,
  parameter int unsigned     WordWindow   = sbs_pkg::WordWindowDefault
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [7:0]                       text_byte_i,
  input  wire logic                             end_of_text_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic                                  sentence_found_o,
  output logic [sbs_pkg::OffsetWidth-1:0]       start_offset_o,
  output logic [sbs_pkg::OffsetWidth-1:0]       end_offset_o,
  output logic                                  text_done_o,
  output logic                                  length_overflow_o
);

  import sbs_pkg::*;

  localparam int unsigned PosW = $clog2(MaxTextBytes);
  localparam int unsigned LenW = $clog2(WordWindow + 2);
  localparam logic [PosW-1:0] PosLimit = PosW'(MaxTextBytes - 64'd1);
  localparam logic [LenW-1:0] LenMax   = LenW'(WordWindow + 1);

  // Text state.
  logic [PosW-1:0]                pos_q, pos_d;
  logic                           sat_q, sat_d;
  logic                           pend_q, pend_d;
  logic                           open_q, open_d;
  logic [PosW-1:0]                start_q, start_d;
  logic [PosW-1:0]                kept_q, kept_d;
  logic [WordWindow-1:0][7:0]     win_q, win_d;
  logic [LenW-1:0]                wlen_q, wlen_d;

  // Result register.
  logic                           out_valid_q, out_valid_d;
  logic                           found_q, found_d;
  logic [OffsetWidth-1:0]         res_start_q, res_start_d;
  logic [OffsetWidth-1:0]         res_end_q, res_end_d;
  logic                           done_q, done_d;
  logic                           ovf_q, ovf_d;

  logic                           accept;
  logic                           space;
  logic                           split_now;
  logic                           emit_split;
  logic                           is_abbrev;
  logic                           open_mid;
  logic [PosW-1:0]                start_mid;
  logic [PosW-1:0]                kept_mid;
  logic                           has_result;
  logic [7:0]                     lc;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign space      = is_ws_byte(text_byte_i);
  assign split_now  = pend_q && space;
  assign emit_split = split_now && open_q;
  assign is_abbrev  = abbrev_match(win_q[3:0],
                                   wlen_q == LenW'(2),
                                   wlen_q == LenW'(3),
                                   wlen_q == LenW'(4));
  assign open_mid   = space ? (open_q && !split_now) : 1'b1;
  assign start_mid  = (!space && !open_q) ? pos_q : start_q;
  assign kept_mid   = space ? kept_q : pos_q;
  assign has_result = emit_split || end_of_text_i;
  assign lc         = is_upper(text_byte_i) ? (text_byte_i | CaseBit) : text_byte_i;

  always_comb begin
    pos_d   = pos_q;
    sat_d   = sat_q;
    pend_d  = pend_q;
    open_d  = open_q;
    start_d = start_q;
    kept_d  = kept_q;
    win_d   = win_q;
    wlen_d  = wlen_q;

    out_valid_d = out_valid_q && !out_ready_i;
    found_d     = found_q;
    res_start_d = res_start_q;
    res_end_d   = res_end_q;
    done_d      = done_q;
    ovf_d       = ovf_q;

    if (accept) begin
      if (pos_q < PosLimit) begin
        pos_d = pos_q + PosW'(1);
      end else begin
        sat_d = 1'b1;
      end

      // A closer keeps a pending end alive; anything else but space re-judges.
      if (split_now) begin
        pend_d = 1'b0;
      end else if (pend_q && is_closing_byte(text_byte_i)) begin
        pend_d = 1'b1;
      end else begin
        pend_d = (text_byte_i == ChBang) || (text_byte_i == ChQuest) ||
                 ((text_byte_i == ChDot) && !is_abbrev);
      end

      open_d  = open_mid;
      start_d = start_mid;
      kept_d  = kept_mid;

      if (is_alpha(text_byte_i) || text_byte_i == ChDot) begin
        win_d = {win_q[WordWindow-2:0], lc};
        if (wlen_q < LenMax) begin
          wlen_d = wlen_q + LenW'(1);
        end
      end else begin
        wlen_d = '0;
      end

      out_valid_d = has_result;
      ovf_d       = sat_q;
      if (emit_split) begin
        found_d     = 1'b1;
        res_start_d = OffsetWidth'(start_q);
        res_end_d   = OffsetWidth'(kept_q);
        done_d      = end_of_text_i;
      end else if (end_of_text_i) begin
        found_d     = open_mid;
        res_start_d = open_mid ? OffsetWidth'(start_mid) : '0;
        res_end_d   = open_mid ? OffsetWidth'(kept_mid) : '0;
        done_d      = 1'b1;
      end

      // The final byte starts the next text from a clean state.
      if (end_of_text_i) begin
        pos_d  = '0;
        sat_d  = 1'b0;
        pend_d = 1'b0;
        open_d = 1'b0;
        wlen_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      sat_q       <= 1'b0;
      pend_q      <= 1'b0;
      open_q      <= 1'b0;
      wlen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      sat_q       <= sat_d;
      pend_q      <= pend_d;
      open_q      <= open_d;
      wlen_q      <= wlen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q     <= start_d;
    kept_q      <= kept_d;
    win_q       <= win_d;
    found_q     <= found_d;
    res_start_q <= res_start_d;
    res_end_q   <= res_end_d;
    done_q      <= done_d;
    ovf_q       <= ovf_d;
  end

  assign out_valid_o       = out_valid_q;
  assign sentence_found_o  = found_q;
  assign start_offset_o    = res_start_q;
  assign end_offset_o      = res_end_q;
  assign text_done_o       = done_q;
  assign length_overflow_o = ovf_q;

  `SBS_ASSERT_SAME(a_sat_at_limit, sat_q, pos_q == PosLimit)
  `SBS_ASSERT_SAME(a_open_ordered, open_q, start_q <= kept_q)
  `SBS_ASSERT_NEXT(a_final_clears, accept && end_of_text_i,
                   pos_q == '0 && !open_q && !pend_q && out_valid_q && done_q)
  `SBS_ASSERT_SAME(a_empty_is_done, out_valid_q && !found_q, done_q)

endmodule

`default_nettype wire

// ----- tb/sentence_boundary_splitter_tb.sv -----
// ---------------------------------------------------------------------------
// Sentence boundary splitter testbench
// Sends byte texts through the splitter and checks every reported sentence
// against a cycle-free predictor or a pinned expectation. A directed script runs first, then random
// texts under mixed idling.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module sentence_boundary_splitter_tb;

  import sbs_pkg::*;

  localparam logic [15:0] LastOfs       = 16'hFFFF;
  localparam int          PhaseBytes    = 190;
  localparam int          HoldCycles    = 300;
  localparam int          CycleLimit    = 1000000;
  localparam logic [7:0]  ChLf          = 8'h0A;
  localparam logic [7:0]  ChVt          = 8'h0B;
  localparam logic [7:0]  ChFf          = 8'h0C;
  localparam logic [7:0]  ChHigh        = 8'hFF;

  typedef struct packed {
    logic        found;
    logic [15:0] first_ofs;
    logic [15:0] last_ofs;
    logic        done;
    logic        ovf;
  } sentence_t;

  typedef struct packed {
    logic      on;
    sentence_t want;
  } pin_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    pin_t       pin;
  } script_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  text_byte_i;
  logic        end_of_text_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        sentence_found_o;
  logic [15:0] start_offset_o;
  logic [15:0] end_offset_o;
  logic        text_done_o;
  logic        length_overflow_o;

  sentence_boundary_splitter DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .text_byte_i      (text_byte_i),
    .end_of_text_i    (end_of_text_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .sentence_found_o (sentence_found_o),
    .start_offset_o   (start_offset_o),
    .end_offset_o     (end_offset_o),
    .text_done_o      (text_done_o),
    .length_overflow_o(length_overflow_o)
  );

  // Predictor state of the splitter.
  logic [15:0] next_ofs;
  bit          ofs_sat;
  bit          end_pending;
  bit          in_sentence;
  logic [15:0] sent_first;
  logic [15:0] sent_last;
  logic [7:0]  word_win [4];
  logic [2:0]  word_run;

  sentence_t   expected_q [$];
  pin_t        pinned_q [$];
  logic [7:0]  text_buf [$];
  script_row_t script [25];

  int          mismatches = 0;
  int          cycle_count = 0;
  int          send_gap_pct;
  int          recv_stall_pct;
  logic [7:0]  hold_token;
  logic [7:0]  hold_seen;
  int          hold_left;

  function automatic bit is_blank(input logic [7:0] c);
    return c == ChSpace || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic void clear_text_state();
    next_ofs    = '0;
    ofs_sat     = 0;
    end_pending = 0;
    in_sentence = 0;
    sent_first  = '0;
    sent_last   = '0;
    word_run    = '0;
    for (int i = 0; i < 4; i++) word_win[i] = '0;
  endfunction

  // Advances the predictor by one byte; returns 1 when the byte yields a result.
  function automatic bit split_step(input logic [7:0] c, input bit last,
                                    output sentence_t res);
    logic [15:0] here;
    logic [31:0] w;
    bit          sat_before;
    bit          ws;
    bit          got;
    bit          abbrev;
    here       = next_ofs;
    sat_before = ofs_sat;
    ws         = is_blank(c);
    got        = 0;
    res        = '0;
    w          = {word_win[0], word_win[1], word_win[2], word_win[3]};
    case (word_run)
      3'd2: begin
        case (w[15:0])
          "mr", "ms", "dr", "st", "jr", "sr", "vs", "no": abbrev = 1;
          default: abbrev = 0;
        endcase
      end
      3'd3: begin
        case (w[23:0])
          "mrs", "etc", "e.g", "i.e", "fig": abbrev = 1;
          default: abbrev = 0;
        endcase
      end
      3'd4: begin
        abbrev = (w == "prof");
      end
      default: begin
        abbrev = 0;
      end
    endcase

    if (next_ofs != LastOfs) next_ofs = next_ofs + 16'd1;
    else ofs_sat = 1;

    if (end_pending && ws) begin
      if (in_sentence) begin
        res = {1'b1, sent_first, sent_last, last, sat_before};
        got = 1;
      end
      in_sentence = 0;
      end_pending = 0;
    end else if (end_pending && (c == ChDquote || c == ChSquote || c == ChRparen ||
                                 c == ChRbrack || c == ChUtfLead)) begin
      // A closing quote or bracket stays with the sentence that is about to end.
    end else begin
      end_pending = (c == ChBang) || (c == ChQuest) || (c == ChDot && !abbrev);
    end

    if (!ws) begin
      if (!in_sentence) begin
        in_sentence = 1;
        sent_first  = here;
      end
      sent_last = here;
    end

    if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == ChDot) begin
      for (int i = 0; i < 3; i++) word_win[i] = word_win[i+1];
      word_win[3] = (c >= 8'h41 && c <= 8'h5A) ? (c | CaseBit) : c;
      if (word_run < 3'd5) word_run = word_run + 3'd1;
    end else begin
      word_run = '0;
    end

    if (last) begin
      if (!got) begin
        if (in_sentence) res = {1'b1, sent_first, sent_last, 1'b1, sat_before};
        else res = {1'b0, 16'd0, 16'd0, 1'b1, sat_before};
        got = 1;
      end
      clear_text_state();
    end
    return got;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 100) begin
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    end
  endtask

  function automatic void add_byte(input logic [7:0] c);
    text_buf.insert(text_buf.size(), c);
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(5))
      0: return ChSpace;
      1: return ChTab;
      2: return ChLf;
      3: return ChVt;
      4: return ChFf;
      default: return ChCr;
    endcase
  endfunction

  function automatic logic [7:0] pick_stop();
    case ($urandom_range(3))
      0: return ChBang;
      1: return ChQuest;
      default: return ChDot;
    endcase
  endfunction

  function automatic logic [7:0] pick_closer();
    case ($urandom_range(4))
      0: return ChDquote;
      1: return ChSquote;
      2: return ChRparen;
      3: return ChRbrack;
      default: return ChUtfLead;
    endcase
  endfunction

  function automatic string abbrev_word(input int k);
    case (k)
      0: return "mr";
      1: return "mrs";
      2: return "ms";
      3: return "dr";
      4: return "prof";
      5: return "st";
      6: return "jr";
      7: return "sr";
      8: return "vs";
      9: return "etc";
      10: return "e.g";
      11: return "i.e";
      12: return "fig";
      default: return "no";
    endcase
  endfunction

  // Builds a short text of words, abbreviations, terminators, closers and
  // stray bytes into text_buf.
  task automatic compose_text();
    string      ab;
    logic [7:0] c;
    int         k;
    text_buf.delete();
    if ($urandom_range(19) == 0) begin
      repeat ($urandom_range(1, 3)) add_byte(pick_blank());
    end else begin
      if ($urandom_range(4) == 0) add_byte(pick_blank());
      repeat ($urandom_range(1, 8)) begin
        k = $urandom_range(99);
        if (k < 15) begin
          ab = abbrev_word($urandom_range(13));
          for (int i = 0; i < ab.len(); i++) begin
            c = ab[i];
            if (c != ChDot && $urandom_range(2) == 0) c = c ^ CaseBit;
            add_byte(c);
          end
          if ($urandom_range(4) < 3) add_byte(ChDot);
        end else if (k < 25) begin
          add_byte(8'($urandom_range(255)));
        end else begin
          repeat ($urandom_range(1, 6)) begin
            c = 8'h61 + 8'($urandom_range(25));
            if ($urandom_range(4) == 0) c = c ^ CaseBit;
            add_byte(c);
          end
        end
        if ($urandom_range(99) < 40) begin
          add_byte(pick_stop());
          repeat ($urandom_range(0, 2)) add_byte(pick_closer());
        end
        if ($urandom_range(9) != 0) begin
          repeat ($urandom_range(1, 2)) add_byte(pick_blank());
        end
      end
    end
  endtask

  // Offers one request and returns at the edge that accepts it.
  task automatic push_byte(input logic [7:0] c, input bit last, input pin_t pin);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    pinned_q.insert(pinned_q.size(), pin);
    in_valid_i    <= 1'b1;
    text_byte_i   <= c;
    end_of_text_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_text(input bit close_text);
    for (int i = 0; i < text_buf.size(); i++) begin
      push_byte(text_buf[i], close_text && (i == text_buf.size() - 1), '0);
    end
  endtask

  function automatic script_row_t row(input logic [7:0] c, input bit last);
    return {c, last, 1'b0, sentence_t'('0)};
  endfunction

  function automatic script_row_t pinned_row(input logic [7:0] c, input bit last,
                                             input sentence_t want);
    return {c, last, 1'b1, want};
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever hold_token moves.
  initial begin
    out_ready_i = 1'b0;
    hold_seen   = '0;
    hold_left   = 0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_token) begin
        hold_seen = hold_token;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    sentence_t seen;
    sentence_t want;
    sentence_t fresh;
    pin_t      pin;
    bit        made;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        seen = {sentence_found_o, start_offset_o, end_offset_o, text_done_o,
                length_overflow_o};
        if (expected_q.size() == 0) begin
          report_mismatch("result with none expected", 32'd1, 32'd0);
        end else begin
          want = expected_q.pop_front();
          if (seen.found !== want.found)
            report_mismatch("sentence_found", 32'(seen.found), 32'(want.found));
          if (seen.first_ofs !== want.first_ofs)
            report_mismatch("start_offset", 32'(seen.first_ofs), 32'(want.first_ofs));
          if (seen.last_ofs !== want.last_ofs)
            report_mismatch("end_offset", 32'(seen.last_ofs), 32'(want.last_ofs));
          if (seen.done !== want.done)
            report_mismatch("text_done", 32'(seen.done), 32'(want.done));
          if (seen.ovf !== want.ovf)
            report_mismatch("length_overflow", 32'(seen.ovf), 32'(want.ovf));
        end
      end
      if (in_valid_i && in_ready_o) begin
        pin  = pinned_q.pop_front();
        made = split_step(text_byte_i, end_of_text_i, fresh);
        if (pin.on) expected_q.insert(expected_q.size(), pin.want);
        else if (made) expected_q.insert(expected_q.size(), fresh);
      end
    end
  end

  initial begin
    int total;
    clear_text_state();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_token     = '0;
    in_valid_i     = 1'b0;
    text_byte_i    = '0;
    end_of_text_i  = 1'b0;
    rst_ni         = 1'b0;

    // Blank-only text, one-byte text at the top byte value, a sentence that
    // ends after a closing quote, abbreviations in mixed case, a terminator
    // cancelled by a following letter, and a text ending on an abbreviation.
    script[0]  = pinned_row(ChSpace, 1, {1'b0, 16'd0, 16'd0, 1'b1, 1'b0});
    script[1]  = pinned_row(ChHigh, 1, {1'b1, 16'd0, 16'd0, 1'b1, 1'b0});
    script[2]  = row("D", 0);
    script[3]  = row("r", 0);
    script[4]  = row(ChDot, 0);
    script[5]  = row(ChSpace, 0);
    script[6]  = row("A", 0);
    script[7]  = row(ChQuest, 0);
    script[8]  = row(ChDquote, 0);
    script[9]  = row(ChSpace, 0);
    script[10] = row("e", 0);
    script[11] = row(ChDot, 0);
    script[12] = row("g", 0);
    script[13] = row(ChDot, 0);
    script[14] = row(ChTab, 0);
    script[15] = row("a", 0);
    script[16] = row(ChBang, 0);
    script[17] = row("b", 0);
    script[18] = row(ChDot, 0);
    script[19] = row(ChUtfLead, 0);
    script[20] = row(ChCr, 1);
    script[21] = row("S", 0);
    script[22] = row("t", 0);
    script[23] = row(ChDot, 0);
    script[24] = pinned_row(ChVt, 1, {1'b1, 16'd0, 16'd2, 1'b1, 1'b0});

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) push_byte(script[i].ch, script[i].last, script[i].pin);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_gap_pct   <= 0;
          recv_stall_pct <= 0;
          hold_token     <= hold_token + 8'd1;
        end
        1: begin
          send_gap_pct   <= 45;
          recv_stall_pct <= 0;
        end
        2: begin
          send_gap_pct   <= 0;
          recv_stall_pct <= 45;
        end
        default: begin
          send_gap_pct   <= 18;
          recv_stall_pct <= 18;
        end
      endcase
      total = 0;
      while (total < PhaseBytes) begin
        compose_text();
        total += text_buf.size();
        send_text(1);
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
